/* design/ps2_mouse_device_engine_assert.svh */
// ---------------------------------------------------------------------------
// ps2_mouse_device_engine_assert.svh
// Assertion macros shared by the PS/2 mouse device engine modules
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_DEVICE_ENGINE_ASSERT_SVH
`define PS2_MOUSE_DEVICE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PS2ME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PS2ME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ps2me_pkg.sv */
// ---------------------------------------------------------------------------
// ps2me_pkg
// Types, codes and constants of the PS/2 mouse device engine
// ---------------------------------------------------------------------------
package ps2me_pkg;

    // host command codes
    localparam logic [7:0] CMD_RESET      = 8'hFF;
    localparam logic [7:0] CMD_RESEND     = 8'hFE;
    localparam logic [7:0] CMD_GET_ID     = 8'hF2;
    localparam logic [7:0] CMD_STATUS     = 8'hE9;
    localparam logic [7:0] CMD_ENABLE     = 8'hF4;
    localparam logic [7:0] CMD_SET_RES    = 8'hE8;
    localparam logic [7:0] CMD_SET_RATE   = 8'hF3;
    localparam logic [7:0] CMD_NULL       = 8'h00;

    // reply bytes
    localparam logic [7:0] ACK_BYTE       = 8'hFA;
    localparam logic [7:0] BAT_OK_BYTE    = 8'hAA;
    localparam logic [7:0] STATUS_RES     = 8'h02;
    localparam logic [7:0] STATUS_RATE    = 8'h64;

    // mouse modes, also the device id
    localparam logic [2:0] MODE_GENERIC   = 3'd0;
    localparam logic [2:0] MODE_WHEEL     = 3'd3;
    localparam logic [2:0] MODE_FIVE      = 3'd4;

    // operation codes
    localparam logic OP_HOST  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // event kinds
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_MOTION  = 2'd2;
    localparam logic [1:0] EV_OTHER   = 2'd3;

    // button codes
    localparam logic [2:0] BTN_NONE    = 3'd0;
    localparam logic [2:0] BTN_LEFT    = 3'd1;
    localparam logic [2:0] BTN_RIGHT   = 3'd2;
    localparam logic [2:0] BTN_MIDDLE  = 3'd3;
    localparam logic [2:0] BTN_BACK    = 3'd4;
    localparam logic [2:0] BTN_FORWARD = 3'd5;

    // packet bits
    localparam logic [7:0] PKT_BASE    = 8'b0000_1000;
    localparam logic [7:0] PKT_X_NEG   = 8'b0001_1000;
    localparam logic [7:0] PKT_Y_NEG   = 8'b0010_1000;
    localparam logic [7:0] PKT_LEFT    = 8'b0000_0001;
    localparam logic [7:0] PKT_RIGHT   = 8'b0000_0010;
    localparam logic [7:0] PKT_MIDDLE  = 8'b0000_0100;
    localparam logic [7:0] WHEEL_UP    = 8'h01;
    localparam logic [7:0] WHEEL_DOWN  = 8'hFF;
    localparam logic [7:0] WHEEL_NONE  = 8'h00;

    // history depth and knock sequences, index 0 is the oldest byte
    localparam int HIST_DEPTH = 6;
    localparam logic [HIST_DEPTH-1:0][7:0] KNOCK_WHEEL =
        {8'h50, 8'hF3, 8'h64, 8'hF3, 8'hC8, 8'hF3};
    localparam logic [HIST_DEPTH-1:0][7:0] KNOCK_FIVE =
        {8'h50, 8'hF3, 8'hC8, 8'hF3, 8'hC8, 8'hF3};

    // reply record passed from front to back
    localparam int REPLY_MAX = 4;
    typedef struct packed {
        logic [REPLY_MAX-1:0][7:0] data;      // data[0] goes out first
        logic [1:0]                last_idx;  // index of the final byte
    } reply_t;

    // default queue depth
    localparam int QUEUE_DEPTH_DEF = 2;

endpackage

/* design/ps2me_front.sv */
// ---------------------------------------------------------------------------
// ps2me_front
// Accepts items, keeps device state and builds the reply record
// ---------------------------------------------------------------------------
module ps2me_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [7:0]            cmd_byte,
    input  logic [1:0]            event_kind,
    input  logic [2:0]            button,
    input  logic signed [8:0]     delta_x,
    input  logic signed [8:0]     delta_y,
    input  logic                  queue_full,
    output logic                  push,
    output ps2me_pkg::reply_t     push_reply
);
    import ps2me_pkg::*;

    logic [HIST_DEPTH-1:0][7:0] hist_reg, hist_next;
    logic [2:0] mode_reg, mode_next;
    logic       enabled_reg, enabled_next;
    logic       init_reg, init_next;
    logic       await_reg, await_next;

    logic       accept;
    logic       has_reply;
    logic       hist_shift;
    reply_t     reply;
    logic [7:0] status_byte;
    logic [7:0] wheel_byte;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // packet status and wheel bytes
    always_comb
    begin
        status_byte = PKT_BASE;
        wheel_byte  = WHEEL_NONE;
        if (delta_x[8])
        begin
            status_byte = status_byte | PKT_X_NEG;
        end
        if (delta_y[8])
        begin
            status_byte = status_byte | PKT_Y_NEG;
        end
        if (event_kind == EV_PRESS)
        begin
            case (button)
                BTN_LEFT:    status_byte = status_byte | PKT_LEFT;
                BTN_RIGHT:   status_byte = status_byte | PKT_RIGHT;
                BTN_MIDDLE:  status_byte = status_byte | PKT_MIDDLE;
                BTN_FORWARD: wheel_byte  = WHEEL_UP;
                BTN_BACK:    wheel_byte  = WHEEL_DOWN;
                default:     wheel_byte  = WHEEL_NONE;
            endcase
        end
    end

    // classify the item and work out the reply and next state
    always_comb
    begin
        hist_next    = hist_reg;
        mode_next    = mode_reg;
        enabled_next = enabled_reg;
        init_next    = init_reg;
        await_next   = await_reg;
        has_reply    = 1'b0;
        hist_shift   = 1'b0;
        reply.data   = '0;
        reply.last_idx = 2'd0;

        if (operation == OP_HOST)
        begin
            has_reply     = 1'b1;
            hist_shift    = 1'b1;
            reply.data[0] = ACK_BYTE;
            if (cmd_byte == CMD_RESET || cmd_byte == CMD_RESEND)
            begin
                mode_next      = MODE_GENERIC;
                enabled_next   = 1'b0;
                init_next      = 1'b1;
                reply.data[1]  = BAT_OK_BYTE;
                reply.data[2]  = {5'd0, MODE_GENERIC};
                reply.last_idx = 2'd2;
            end
            else if (cmd_byte == CMD_GET_ID)
            begin
                reply.last_idx = 2'd1;
                if (hist_reg == KNOCK_WHEEL)
                begin
                    mode_next     = MODE_WHEEL;
                    reply.data[1] = {5'd0, MODE_WHEEL};
                end
                else if (hist_reg == KNOCK_FIVE)
                begin
                    mode_next     = MODE_FIVE;
                    reply.data[1] = {5'd0, MODE_FIVE};
                end
                else
                begin
                    reply.data[1] = {5'd0, MODE_GENERIC};
                end
            end
            else if (cmd_byte == CMD_STATUS)
            begin
                reply.data[1]  = {5'd0, mode_reg};
                reply.data[2]  = STATUS_RES;
                reply.data[3]  = STATUS_RATE;
                reply.last_idx = 2'd3;
            end
            else if (cmd_byte == CMD_ENABLE)
            begin
                enabled_next = 1'b1;
            end
            else if (cmd_byte == CMD_SET_RES || cmd_byte == CMD_SET_RATE)
            begin
                await_next = 1'b1;
            end
            else if (await_reg)
            begin
                await_next = 1'b0;
            end
            else if (cmd_byte == CMD_NULL)
            begin
                // stray zero byte: silently dropped
                has_reply  = 1'b0;
                hist_shift = 1'b0;
            end
            if (hist_shift)
            begin
                hist_next = {cmd_byte, hist_reg[HIST_DEPTH-1:1]};
            end
        end
        else
        begin
            reply.data[0] = status_byte;
            reply.data[1] = delta_x[7:0];
            reply.data[2] = delta_y[7:0];
            reply.data[3] = wheel_byte;
            reply.last_idx = (mode_reg != MODE_GENERIC) ? 2'd3 : 2'd2;
            has_reply = (event_kind != EV_OTHER) && init_reg && enabled_reg;
        end
    end

    assign push       = accept && has_reply;
    assign push_reply = reply;

    // device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= '0;
            mode_reg    <= MODE_GENERIC;
            enabled_reg <= 1'b0;
            init_reg    <= 1'b0;
            await_reg   <= 1'b0;
        end
        else if (accept)
        begin
            hist_reg    <= hist_next;
            mode_reg    <= mode_next;
            enabled_reg <= enabled_next;
            init_reg    <= init_next;
            await_reg   <= await_next;
        end
    end

endmodule

/* design/ps2me_queue.sv */
// ---------------------------------------------------------------------------
// ps2me_queue
// Short queue of reply records between front and back
// ---------------------------------------------------------------------------
module ps2me_queue #(
    parameter int DEPTH = ps2me_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ps2me_pkg::reply_t     push_reply,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output ps2me_pkg::reply_t     head_reply
);
    import ps2me_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    reply_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_reply = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_reply;
        end
    end

`include "ps2_mouse_device_engine_assert.svh"

    `PS2ME_ASSERT_NOW(a_no_push_full, full, !push, "queue: push while full")
    `PS2ME_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_FULL, "queue: count overflow")
    `PS2ME_ASSERT_NEXT(a_pop_drops, pop && !push, count_reg == $past(count_reg) - 1'b1,
        "queue: pop did not drop count")

endmodule

/* design/ps2me_back.sv */
// ---------------------------------------------------------------------------
// ps2me_back
// Sends the bytes of each reply record out one byte per cycle while out_stall is low
// ---------------------------------------------------------------------------
module ps2me_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  ps2me_pkg::reply_t     head_reply,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            tx_byte,
    output logic                  last_byte
);
    import ps2me_pkg::*;

    reply_t     cur_reg;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       out_fire;
    logic       at_last;

    assign out_valid = busy_reg;
    assign at_last   = (idx_reg == cur_reg.last_idx);
    assign tx_byte   = cur_reg.data[idx_reg];
    assign last_byte = at_last;
    assign out_fire  = busy_reg && !out_stall;

    // take the next record when idle or when the final byte leaves
    assign pop = head_valid && (!busy_reg || (out_fire && at_last));

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_reply;
        end
    end

`include "ps2_mouse_device_engine_assert.svh"

    `PS2ME_ASSERT_NOW(a_pop_has_head, pop, head_valid, "back: pop from empty queue")
    `PS2ME_ASSERT_NOW(a_idx_bound, busy_reg, idx_reg <= cur_reg.last_idx,
        "back: byte index past end of record")
    `PS2ME_ASSERT_NEXT(a_goes_idle, out_fire && at_last && !head_valid, !busy_reg,
        "back: still busy after final byte")

endmodule

/* design/ps2_mouse_device_engine.sv */
// ---------------------------------------------------------------------------
// ps2_mouse_device_engine
// PS/2 mouse device side with wheel and five-button extensions
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   in       | in_valid / in_stall | operation cmd_byte event_kind button
//            |                     | delta_x delta_y batch_end
//   out      | out_valid/out_stall | tx_byte last_byte
//
// An accepted item yields zero to four bytes; the back end sends one byte a
// cycle while out_stall is low.
// The front takes an item each cycle while the reply queue has room.
// Reset clears the command history, mode and flags at once; no sweep.
// A stall on out backs up the queue, then holds in_stall high.
// ---------------------------------------------------------------------------
module ps2_mouse_device_engine #(
    parameter int QUEUE_DEPTH = ps2me_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [7:0]        cmd_byte,
    input  logic [1:0]        event_kind,
    input  logic [2:0]        button,
    input  logic signed [8:0] delta_x,
    input  logic signed [8:0] delta_y,
    input  logic              batch_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        tx_byte,
    output logic              last_byte
);
    import ps2me_pkg::*;

    logic   queue_full;
    logic   push;
    reply_t push_reply;
    logic   pop;
    logic   head_valid;
    reply_t head_reply;
    logic   batch_end_unused;

    // batch marker carries no meaning for the replies
    assign batch_end_unused = batch_end;

    ps2me_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .cmd_byte   (cmd_byte),
        .event_kind (event_kind),
        .button     (button),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .queue_full (queue_full),
        .push       (push),
        .push_reply (push_reply)
    );

    ps2me_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_reply (push_reply),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_reply (head_reply)
    );

    ps2me_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_reply (head_reply),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

endmodule

/* test/ps2_mouse_device_engine_tb.sv */
// ---------------------------------------------------------------------------
// ps2_mouse_device_engine_tb
// Self-checking bench for the PS/2 mouse device engine: a behavioral
// predictor tracks the command history, mode and flags and queues the bytes
// each accepted item should produce; every byte leaving the block is checked
// in order against that queue while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module ps2_mouse_device_engine_tb;

    import ps2me_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 110;
    localparam int SETTLE_CYCLES = 32;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } tx_expect_t;

    // clock, reset and block ports
    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              operation  = OP_HOST;
    logic [7:0]        cmd_byte   = 8'h00;
    logic [1:0]        event_kind = EV_PRESS;
    logic [2:0]        button     = BTN_NONE;
    logic signed [8:0] delta_x    = '0;
    logic signed [8:0] delta_y    = '0;
    logic              batch_end  = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [7:0]        tx_byte;
    logic              last_byte;

    // predicted device state
    logic [7:0] cmd_hist [HIST_DEPTH];
    logic [2:0] dev_mode;
    logic       report_on;
    logic       powered_up;
    logic       param_pending;

    tx_expect_t tx_expect_q[$];
    int         fail_count    = 0;
    int         sent_items    = 0;
    int         cycle_count   = 0;
    logic       no_idle       = 1'b0;

    ps2_mouse_device_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .cmd_byte   (cmd_byte),
        .event_kind (event_kind),
        .button     (button),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .batch_end  (batch_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // runaway guard
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // motion value biased toward the extremes
    function automatic logic [8:0] pick_motion();
        case ($urandom_range(0, 7))
            0:       return 9'h100;
            1:       return 9'h0FF;
            2:       return 9'h1FF;
            3:       return 9'h000;
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    // bytes the device sends for one item, queued in order
    function automatic int predict_tx_bytes(input logic op, input logic [7:0] hb,
                                            input logic [1:0] kind, input logic [2:0] btn,
                                            input logic [8:0] mx, input logic [8:0] my);
        logic [7:0] rep [REPLY_MAX];
        logic [7:0] status;
        logic [7:0] wheel;
        logic [7:0] dev_id;
        logic       hit_wheel;
        logic       hit_five;
        logic       ignored;
        int         n;
        n       = 0;
        ignored = 1'b0;
        if (op == OP_HOST)
        begin
            if (hb == CMD_RESET || hb == CMD_RESEND)
            begin
                dev_mode   = MODE_GENERIC;
                report_on  = 1'b0;
                powered_up = 1'b1;
                rep[0] = ACK_BYTE;
                rep[1] = BAT_OK_BYTE;
                rep[2] = {5'b0, MODE_GENERIC};
                n = 3;
            end
            else if (hb == CMD_GET_ID)
            begin
                // knock match against the last six host bytes, oldest first
                hit_wheel = 1'b1;
                hit_five  = 1'b1;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    if (cmd_hist[i] != KNOCK_WHEEL[i])
                        hit_wheel = 1'b0;
                    if (cmd_hist[i] != KNOCK_FIVE[i])
                        hit_five = 1'b0;
                end
                dev_id = {5'b0, MODE_GENERIC};
                if (hit_wheel)
                begin
                    dev_mode = MODE_WHEEL;
                    dev_id   = {5'b0, MODE_WHEEL};
                end
                else if (hit_five)
                begin
                    dev_mode = MODE_FIVE;
                    dev_id   = {5'b0, MODE_FIVE};
                end
                rep[0] = ACK_BYTE;
                rep[1] = dev_id;
                n = 2;
            end
            else if (hb == CMD_STATUS)
            begin
                rep[0] = ACK_BYTE;
                rep[1] = {5'b0, dev_mode};
                rep[2] = STATUS_RES;
                rep[3] = STATUS_RATE;
                n = 4;
            end
            else if (hb == CMD_ENABLE)
            begin
                report_on = 1'b1;
                rep[0] = ACK_BYTE;
                n = 1;
            end
            else if (hb == CMD_SET_RES || hb == CMD_SET_RATE)
            begin
                param_pending = 1'b1;
                rep[0] = ACK_BYTE;
                n = 1;
            end
            else if (param_pending)
            begin
                param_pending = 1'b0;
                rep[0] = ACK_BYTE;
                n = 1;
            end
            else if (hb == CMD_NULL)
                ignored = 1'b1;
            else
            begin
                rep[0] = ACK_BYTE;
                n = 1;
            end
            // history shifts toward index 0
            if (!ignored)
            begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    cmd_hist[i] = cmd_hist[i + 1];
                cmd_hist[HIST_DEPTH - 1] = hb;
            end
        end
        else if (kind != EV_OTHER)
        begin
            // packet: status, x, y and the wheel byte in extended modes
            status = PKT_BASE;
            wheel  = WHEEL_NONE;
            if (mx[8])
                status |= PKT_X_NEG;
            if (my[8])
                status |= PKT_Y_NEG;
            if (kind == EV_PRESS)
            begin
                case (btn)
                    BTN_LEFT:    status |= PKT_LEFT;
                    BTN_RIGHT:   status |= PKT_RIGHT;
                    BTN_MIDDLE:  status |= PKT_MIDDLE;
                    BTN_FORWARD: wheel = WHEEL_UP;
                    BTN_BACK:    wheel = WHEEL_DOWN;
                    default:     wheel = WHEEL_NONE;
                endcase
            end
            if (powered_up && report_on)
            begin
                rep[0] = status;
                rep[1] = mx[7:0];
                rep[2] = my[7:0];
                n = 3;
                if (dev_mode != MODE_GENERIC)
                begin
                    rep[3] = wheel;
                    n = 4;
                end
            end
        end
        for (int i = 0; i < n; i++)
            tx_expect_q.push_back('{tx: rep[i], last: (i == n - 1)});
        return n;
    endfunction

    task automatic report_mismatch(input string why,
                                   input logic [7:0] exp_tx, input logic exp_last,
                                   input logic [7:0] got_tx, input logic got_last);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch (%s): expected tx_byte=%h last_byte=%b, got tx_byte=%h last_byte=%b",
                     why, exp_tx, exp_last, got_tx, got_last);
    endtask

    // one item on the input channel, held until accepted
    task automatic send_item(input logic op, input logic [7:0] hb,
                             input logic [1:0] kind, input logic [2:0] btn,
                             input logic [8:0] mx, input logic [8:0] my);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        cmd_byte   <= hb;
        event_kind <= kind;
        button     <= btn;
        delta_x    <= mx;
        delta_y    <= my;
        batch_end  <= 1'($urandom_range(0, 1));
        do
            @(posedge clk);
        while (in_stall);
        void'(predict_tx_bytes(op, hb, kind, btn, mx, my));
        sent_items++;
    endtask

    task automatic send_host(input logic [7:0] hb);
        send_item(OP_HOST, hb, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  pick_motion(), pick_motion());
    endtask

    task automatic send_mouse(input logic [1:0] kind, input logic [2:0] btn,
                              input logic [8:0] mx, input logic [8:0] my);
        send_item(OP_EVENT, 8'($urandom_range(0, 255)), kind, btn, mx, my);
    endtask

    // hold the sender until every queued byte has come out
    task automatic wait_replies_drained();
        in_valid <= 1'b0;
        while (tx_expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_knock(input logic five);
        for (int i = 0; i < HIST_DEPTH; i++)
            send_host(five ? KNOCK_FIVE[i] : KNOCK_WHEEL[i]);
    endtask

    // events before power-up, the ignored zero byte, resend, enable, status
    task automatic test_power_up();
        send_mouse(EV_PRESS, BTN_LEFT, 9'h001, 9'h001);
        send_host(CMD_NULL);
        send_host(CMD_RESEND);
        send_host(CMD_ENABLE);
        send_mouse(EV_MOTION, BTN_NONE, 9'h100, 9'h0FF);
        send_host(CMD_STATUS);
    endtask

    // generic three-byte packets, button bits and sign bits
    task automatic test_generic_packets();
        no_idle = 1'b1;
        send_mouse(EV_PRESS, BTN_RIGHT, 9'h0FF, 9'h100);
        send_mouse(EV_PRESS, BTN_MIDDLE, 9'h000, 9'h000);
        send_mouse(EV_RELEASE, BTN_LEFT, 9'h1FF, 9'h1FF);
        send_mouse(EV_OTHER, BTN_LEFT, 9'h010, 9'h020);
        send_mouse(EV_PRESS, 3'd7, 9'h055, 9'h1AA);
        no_idle = 1'b0;
    endtask

    // reset while a parameter is pending keeps the flag, so zero gets an ack
    task automatic test_parameter_bytes();
        send_host(CMD_SET_RES);
        send_host(CMD_RESET);
        send_host(CMD_NULL);
        send_host(CMD_ENABLE);
    endtask

    // wheel knock then five-button knock, each followed by a packet
    task automatic test_extended_modes();
        send_knock(1'b0);
        send_host(CMD_GET_ID);
        send_mouse(EV_PRESS, BTN_FORWARD, 9'h07F, 9'h180);
        send_knock(1'b1);
        send_host(CMD_GET_ID);
        send_mouse(EV_PRESS, BTN_BACK, 9'h101, 9'h0FE);
    endtask

    // mostly well-formed command sequences and event bursts, some noise
    task automatic test_random_traffic();
        logic [7:0] knock [HIST_DEPTH];
        logic       five;
        logic       drained;
        drained = 1'b0;
        while (sent_items < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if (!drained && sent_items > RANDOM_ITEMS / 2)
            begin
                wait_replies_drained();
                drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // knock, sometimes with one byte broken
                    five = 1'($urandom_range(0, 1));
                    for (int i = 0; i < HIST_DEPTH; i++)
                        knock[i] = five ? KNOCK_FIVE[i] : KNOCK_WHEEL[i];
                    if ($urandom_range(0, 3) == 0)
                        knock[$urandom_range(0, HIST_DEPTH - 1)] = 8'($urandom_range(0, 255));
                    for (int i = 0; i < HIST_DEPTH; i++)
                        send_host(knock[i]);
                    send_host(CMD_GET_ID);
                    if ($urandom_range(0, 1) == 0)
                        send_host(CMD_STATUS);
                end
                2:
                begin
                    send_host($urandom_range(0, 1) ? CMD_RESET : CMD_RESEND);
                    if ($urandom_range(0, 3) != 0)
                        send_host(CMD_ENABLE);
                end
                3:
                    send_host(8'($urandom_range(0, 255)));
                4:
                begin
                    send_host($urandom_range(0, 1) ? CMD_SET_RES : CMD_SET_RATE);
                    send_host($urandom_range(0, 3) == 0 ? CMD_NULL : 8'($urandom_range(0, 255)));
                end
                5:
                    send_host(CMD_STATUS);
                default:
                    repeat ($urandom_range(1, 4))
                        send_mouse(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                   pick_motion(), pick_motion());
            endcase
        end
        no_idle = 1'b0;
    endtask

    // output side: random stall, then compare each accepted byte
    initial
    begin : tx_checker
        int         stall_left;
        logic       got;
        logic [7:0] got_tx;
        logic       got_last;
        tx_expect_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            got      = rst_n && out_valid && !out_stall;
            got_tx   = tx_byte;
            got_last = last_byte;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_stall <= 1'b1;
            end
            #1;
            if (got)
            begin
                if (tx_expect_q.size() == 0)
                    report_mismatch("unexpected byte", 8'hxx, 1'bx, got_tx, got_last);
                else
                begin
                    want = tx_expect_q.pop_front();
                    if (want.tx !== got_tx || want.last !== got_last)
                        report_mismatch("wrong byte", want.tx, want.last, got_tx, got_last);
                end
            end
        end
    end

    // test sequence
    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
            cmd_hist[i] = 8'h00;
        dev_mode      = MODE_GENERIC;
        report_on     = 1'b0;
        powered_up    = 1'b0;
        param_pending = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        wait_replies_drained();
        test_generic_packets();
        wait_replies_drained();
        test_parameter_bytes();
        wait_replies_drained();
        test_extended_modes();
        wait_replies_drained();
        test_random_traffic();
        wait_replies_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // anything still queued never came out
        while (tx_expect_q.size() != 0)
        begin
            report_mismatch("missing byte", tx_expect_q[0].tx, tx_expect_q[0].last,
                            8'hxx, 1'bx);
            void'(tx_expect_q.pop_front());
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
